/* rtl/core/smt_pkg.sv */
// ----------------------------------------------------------------------------
// smt_pkg
// Shared widths, codes and controller/datapath handshake types for the
// sparse matrix transpose unit.
// ----------------------------------------------------------------------------
package smt_pkg;

  // Field widths of the input and result transactions.
  localparam int IDX_W     = 10;
  localparam int DIM_W     = 11;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Input opcodes.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_END   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write the accepted term into the store
    logic start;       // load the header into the pending slot, reset the scan
    logic next_term;   // advance the term index
    logic next_col;    // wrap the term index and advance the column
    logic push_term;   // move pending result out, load the matched term
    logic push_final;  // move pending result out marked last, clear the count
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;  // no terms stored
    logic scan_empty;  // no columns to scan
    logic match;       // the term read this cycle lies in the current column
    logic can_push;    // the output register can take a result
    logic term_last;   // the term index is on the last stored term
    logic col_last;    // the column is the last one of the scan
  } status_t;

endpackage

/* rtl/core/smt_in_if.sv */
// ----------------------------------------------------------------------------
// smt_in_if
// Input channel: one stored term or an end-of-matrix marker per transaction.
// ----------------------------------------------------------------------------
interface smt_in_if import smt_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [IDX_W-1:0]        term_row;
  logic [IDX_W-1:0]        term_col;
  logic signed [VAL_W-1:0] term_value;

  modport source (output valid, opcode, term_row, term_col, term_value, input ready);
  modport sink   (input valid, opcode, term_row, term_col, term_value, output ready);

endinterface

/* rtl/core/smt_out_if.sv */
// ----------------------------------------------------------------------------
// smt_out_if
// Result channel: a header or one transposed term per transaction.
// ----------------------------------------------------------------------------
interface smt_out_if import smt_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    is_header;
  logic [DIM_W-1:0]        out_row;
  logic [DIM_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    overflowed;
  logic                    last;

  modport source (output valid, is_header, out_row, out_col, out_value, overflowed, last,
                  input ready);
  modport sink   (input valid, is_header, out_row, out_col, out_value, overflowed, last,
                  output ready);

endinterface

/* rtl/core/sparse_matrix_transpose_unit.sv */
// Store transaction: accepted while idle; stores may arrive back to back.
// End transaction: per column, over min(num_cols, 2**min(INDEX_BITS, IDX_W))
// columns, each stored term is read and checked (single store read port),
// then the last result goes out; each result leaves when the next is found.
// Reset clears the controller, term count, overflow flag, configuration
// registers and output valid; the term store itself is not cleared.
// ----------------------------------------------------------------------------
// sparse_matrix_transpose_unit
// Collects sparse matrix terms in triplet form and emits the transpose by a
// column scan, preceded by a header with dimensions and term count.
// ----------------------------------------------------------------------------
module sparse_matrix_transpose_unit import smt_pkg::*; #(
  parameter int MAX_NONZERO = 32,
  parameter int INDEX_BITS  = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  smt_in_if.sink               terms,
  smt_out_if.source            results
);

  cmd_t    cmd;
  status_t sts;

  // Controller.
  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (terms.valid),
    .opcode   (terms.opcode),
    .in_ready (terms.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath.
  smt_dp #(
    .MAX_NONZERO (MAX_NONZERO),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .term_row   (terms.term_row),
    .term_col   (terms.term_col),
    .term_value (terms.term_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .is_header  (results.is_header),
    .out_row    (results.out_row),
    .out_col    (results.out_col),
    .out_value  (results.out_value),
    .overflowed (results.overflowed),
    .last       (results.last)
  );

  // An end transaction starts the scan, so input is held off right after it.
  a_end_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (terms.valid && terms.ready && terms.opcode == OP_END) |=> !terms.ready)
    else $error("input accepted right after an end transaction");

  // The header never reports more terms than the store holds.
  a_header_count: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.is_header) |-> (results.out_value <= MAX_NONZERO))
    else $error("header term count exceeds store capacity");

  // The controller never pushes a result while the output register is stuck.
  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_term || cmd.push_final) |-> sts.can_push)
    else $error("result pushed into an occupied output register");

endmodule

/* rtl/core/smt_ctrl.sv */
// ----------------------------------------------------------------------------
// smt_ctrl
// Controller: accepts terms, then walks the column scan one stored term at a
// time and sequences the result pushes.
// ----------------------------------------------------------------------------
module smt_ctrl import smt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    opcode,
  output logic    in_ready,
  output cmd_t    cmd,
  input  status_t sts
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_STORE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = (sts.count_zero || sts.scan_empty) ? ST_FINISH : ST_READ;
          end
        end
      end
      ST_READ: begin
        // The store read issued here returns in the check cycle.
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!(sts.match && !sts.can_push)) begin
          cmd.push_term = sts.match;
          if (sts.term_last) begin
            cmd.next_col = 1'b1;
            state_next   = sts.col_last ? ST_FINISH : ST_READ;
          end else begin
            cmd.next_term = 1'b1;
            state_next    = ST_READ;
          end
        end
      end
      ST_FINISH: begin
        if (sts.can_push) begin
          cmd.push_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/smt_dp.sv */
// ----------------------------------------------------------------------------
// smt_dp
// Datapath: configuration registers, term store, scan counters, pending
// result slot and output register.
// ----------------------------------------------------------------------------
module smt_dp import smt_pkg::*; #(
  parameter int MAX_NONZERO = 32,
  parameter int INDEX_BITS  = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic [IDX_W-1:0]        term_row,
  input  logic [IDX_W-1:0]        term_col,
  input  logic signed [VAL_W-1:0] term_value,
  input  cmd_t                    cmd,
  output status_t                 sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    is_header,
  output logic [DIM_W-1:0]        out_row,
  output logic [DIM_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    overflowed,
  output logic                    last
);

  // Stored index width: indexes are masked to min(INDEX_BITS, IDX_W), ports carry IDX_W.
  localparam int SW     = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int CW     = $clog2(MAX_NONZERO + 1);
  localparam int AW     = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
  localparam int WORD_W = 2 * SW + VAL_W;
  localparam logic [DIM_W-1:0] COL_LIMIT = DIM_W'(1 << SW);
  localparam logic [CW-1:0]    COUNT_MAX = CW'(MAX_NONZERO);

  logic [DIM_W-1:0]  num_rows;
  logic [DIM_W-1:0]  num_cols;
  logic [CW-1:0]     count;
  logic              ovf_flag;
  logic [WORD_W-1:0] mem [MAX_NONZERO];
  logic [WORD_W-1:0] rd_word;
  logic [AW-1:0]     term_idx;
  logic [DIM_W-1:0]  col_cnt;
  logic [DIM_W-1:0]  scan_end;
  logic              full;
  logic              push;

  logic              pend_header;
  logic [DIM_W-1:0]  pend_row;
  logic [DIM_W-1:0]  pend_col;
  logic [VAL_W-1:0]  pend_value;

  logic [SW-1:0]     rd_col;
  logic [SW-1:0]     rd_row;
  logic [VAL_W-1:0]  rd_value;

  assign {rd_col, rd_row, rd_value} = rd_word;

  assign full     = (count == COUNT_MAX);
  assign push     = cmd.push_term || cmd.push_final;
  assign scan_end = (num_cols < COL_LIMIT) ? num_cols : COL_LIMIT;

  // Status toward the controller.
  assign sts.count_zero = (count == '0);
  assign sts.scan_empty = (scan_end == '0);
  assign sts.match      = ({{(DIM_W - SW){1'b0}}, rd_col} == col_cnt);
  assign sts.can_push   = !out_valid || out_ready;
  assign sts.term_last  = ((CW'(term_idx) + CW'(1)) == count);
  assign sts.col_last   = ((col_cnt + DIM_W'(1)) == scan_end);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= '0;
      num_cols <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Term count and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_flag <= 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        ovf_flag <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end else if (cmd.push_final) begin
      count <= '0;
    end
  end

  // Term store: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[count[AW-1:0]] <= {term_col[SW-1:0], term_row[SW-1:0], term_value};
    end
    rd_word <= mem[term_idx];
  end

  // Scan counters: term index within a column, and the column itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_idx <= '0;
      col_cnt  <= '0;
    end else if (cmd.start) begin
      term_idx <= '0;
      col_cnt  <= '0;
    end else if (cmd.next_col) begin
      term_idx <= '0;
      col_cnt  <= col_cnt + DIM_W'(1);
    end else if (cmd.next_term) begin
      term_idx <= term_idx + AW'(1);
    end
  end

  // Pending slot: holds the newest result until it is known whether another
  // one follows, which decides its last flag.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pend_header <= 1'b1;
      pend_row    <= num_cols;
      pend_col    <= num_rows;
      pend_value  <= VAL_W'(count);
    end else if (cmd.push_term) begin
      pend_header <= 1'b0;
      pend_row    <= {{(DIM_W - SW){1'b0}}, rd_col};
      pend_col    <= {{(DIM_W - SW){1'b0}}, rd_row};
      pend_value  <= rd_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      is_header  <= pend_header;
      out_row    <= pend_row;
      out_col    <= pend_col;
      out_value  <= pend_value;
      overflowed <= ovf_flag;
      last       <= cmd.push_final;
    end
  end

endmodule
